@@ rtl/core/ikpt_pkg.sv @@
package ikpt_pkg;

    // table geometry
    localparam int ENTRIES      = 8;
    localparam int PAYLOAD_BITS = 48;
    localparam int INSTANT_BITS = 16;
    localparam int IDX_W        = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

    // operation codes
    localparam logic FUNC_PUT = 1'b0;
    localparam logic FUNC_GET = 1'b1;

    // commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic do_put;
        logic scan;
        logic load_out;
    } ikpt_cmd_t;

    // status from datapath to controller
    typedef struct packed {
        logic is_get;
        logic hit;
        logic last;
        logic out_free;
    } ikpt_status_t;

endpackage

@@ rtl/core/ikpt_ctrl.sv @@
module ikpt_ctrl
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_stall,
    input  ikpt_pkg::ikpt_status_t status,
    output ikpt_pkg::ikpt_cmd_t    cmd
);
    import ikpt_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_PUT  = 4'b0010,
        S_SCAN = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next   = state_reg;
        cmd          = '0;
        in_stall     = 1'b1;
        case (state_reg)
            S_IDLE:
            begin
                in_stall = 1'b0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_DONE;
                end
            end
            S_PUT:
            begin
                state_next = S_DONE;
            end
            S_SCAN:
            begin
                cmd.scan = 1'b1;
                if (status.hit || status.last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // the captured operation picks the work state
        if (state_reg == S_IDLE && in_valid)
        begin
            state_next = status.is_get ? S_SCAN : S_PUT;
        end
        if (state_reg == S_PUT)
        begin
            cmd.do_put = 1'b1;
        end
    end

endmodule

@@ rtl/core/ikpt_datapath.sv @@
module ikpt_datapath
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 func,
    input  logic [ikpt_pkg::INSTANT_BITS-1:0]    key_instant,
    input  logic [ikpt_pkg::PAYLOAD_BITS-1:0]    entry_payload,
    input  logic                                 out_stall,
    output logic                                 out_valid,
    output logic                                 success,
    output logic [ikpt_pkg::INSTANT_BITS-1:0]    out_instant,
    output logic [ikpt_pkg::PAYLOAD_BITS-1:0]    out_payload,
    input  ikpt_pkg::ikpt_cmd_t                   cmd,
    output ikpt_pkg::ikpt_status_t                status
);
    import ikpt_pkg::*;

    logic [ENTRIES-1:0]      valid_reg;
    logic [INSTANT_BITS-1:0] instant_reg [ENTRIES];
    logic [PAYLOAD_BITS-1:0] payload_reg [ENTRIES];

    logic                    func_reg;
    logic [INSTANT_BITS-1:0] key_reg;
    logic [PAYLOAD_BITS-1:0] pay_reg;
    logic [IDX_W-1:0]        idx_reg;

    logic                    res_success_reg;
    logic [INSTANT_BITS-1:0] res_instant_reg;
    logic [PAYLOAD_BITS-1:0] res_payload_reg;

    logic                    out_valid_reg;
    logic                    out_success_reg;
    logic [INSTANT_BITS-1:0] out_instant_reg;
    logic [PAYLOAD_BITS-1:0] out_payload_reg;

    logic                    free_any;
    logic [IDX_W-1:0]        free_idx;

    // lowest free slot, searched from the top down so slot 0 wins
    always_comb
    begin
        free_any = 1'b0;
        free_idx = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_any = 1'b1;
                free_idx = IDX_W'(i);
            end
        end
    end

    // status back to the controller
    always_comb
    begin
        status.is_get   = (func == FUNC_GET);
        status.hit      = valid_reg[idx_reg] && (instant_reg[idx_reg] == key_reg);
        status.last     = (idx_reg == IDX_W'(ENTRIES - 1));
        status.out_free = !out_valid_reg || !out_stall;
    end

    // valid marks
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (cmd.do_put && func_reg == FUNC_PUT && free_any)
        begin
            valid_reg[free_idx] <= 1'b1;
        end
        else if (cmd.scan && status.hit)
        begin
            valid_reg[idx_reg] <= 1'b0;
        end
    end

    // slot contents
    always_ff @(posedge clk)
    begin
        if (cmd.do_put && free_any)
        begin
            instant_reg[free_idx] <= key_reg;
            payload_reg[free_idx] <= pay_reg;
        end
    end

    // request capture, scan index and result
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            func_reg        <= func;
            key_reg         <= key_instant;
            pay_reg         <= entry_payload;
            idx_reg         <= '0;
            res_success_reg <= 1'b0;
            res_instant_reg <= '0;
            res_payload_reg <= '0;
        end
        else if (cmd.do_put)
        begin
            res_success_reg <= free_any;
        end
        else if (cmd.scan)
        begin
            if (status.hit)
            begin
                res_success_reg <= 1'b1;
                res_instant_reg <= instant_reg[idx_reg];
                res_payload_reg <= payload_reg[idx_reg];
            end
            else if (!status.last)
            begin
                idx_reg <= idx_reg + IDX_W'(1);
            end
        end
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_success_reg <= res_success_reg;
            out_instant_reg <= res_instant_reg;
            out_payload_reg <= res_payload_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign success     = out_success_reg;
    assign out_instant = out_instant_reg;
    assign out_payload = out_payload_reg;

endmodule

@@ rtl/core/instant_keyed_pending_table_top.sv @@
// a put steps through the PUT and DONE states, a get through SCAN and DONE, and DONE
// loads the result into the output register; a new request is taken only in IDLE,
//   and the slot scan of a get compares one stored instant per cycle
// the output register lets the next request start while a result waits
// reset clears every valid mark (table empty) and the output valid
module instant_keyed_pending_table_top
(
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 in_valid,
    output logic                                 in_stall,
    input  logic                                 func,
    input  logic [ikpt_pkg::INSTANT_BITS-1:0]    key_instant,
    input  logic [ikpt_pkg::PAYLOAD_BITS-1:0]    entry_payload,
    output logic                                 out_valid,
    input  logic                                 out_stall,
    output logic                                 success,
    output logic [ikpt_pkg::INSTANT_BITS-1:0]    out_instant,
    output logic [ikpt_pkg::PAYLOAD_BITS-1:0]    out_payload
);
    import ikpt_pkg::*;

    ikpt_cmd_t    cmd;
    ikpt_status_t status;

    // sequencing
    ikpt_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .status   (status),
        .cmd      (cmd)
    );

    // table storage and result path
    ikpt_datapath u_datapath
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .func          (func),
        .key_instant   (key_instant),
        .entry_payload (entry_payload),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .success       (success),
        .out_instant   (out_instant),
        .out_payload   (out_payload),
        .cmd           (cmd),
        .status        (status)
    );

endmodule

@@ test/instant_keyed_pending_table_top_tb.sv @@
`timescale 1ns / 1ps

module instant_keyed_pending_table_top_tb;

    import ikpt_pkg::*;

    localparam int RANDOM_ITEMS = 1100;

    // one request as offered, with an optional hand-typed reply
    typedef struct packed {
        logic                    func;
        logic [INSTANT_BITS-1:0] key;
        logic [PAYLOAD_BITS-1:0] payload;
        logic                    typed;
        logic                    exp_ok;
        logic [INSTANT_BITS-1:0] exp_instant;
        logic [PAYLOAD_BITS-1:0] exp_payload;
    } request_t;

    typedef struct packed {
        logic                    ok;
        logic [INSTANT_BITS-1:0] instant;
        logic [PAYLOAD_BITS-1:0] payload;
    } reply_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_stall;
    logic                    func = FUNC_PUT;
    logic [INSTANT_BITS-1:0] key_instant = '0;
    logic [PAYLOAD_BITS-1:0] entry_payload = '0;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic                    success;
    logic [INSTANT_BITS-1:0] out_instant;
    logic [PAYLOAD_BITS-1:0] out_payload;

    // shadow copy of the pending table
    logic                    pend_valid [ENTRIES];
    logic [INSTANT_BITS-1:0] pend_instant [ENTRIES];
    logic [PAYLOAD_BITS-1:0] pend_payload [ENTRIES];

    reply_t   awaited_replies [$];
    request_t directed_rows [$];
    int       error_count = 0;
    int       drawn_count = 0;
    int       rx_cycle = 0;
    int       hold_left = 0;

    instant_keyed_pending_table_top dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .func          (func),
        .key_instant   (key_instant),
        .entry_payload (entry_payload),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .success       (success),
        .out_instant   (out_instant),
        .out_payload   (out_payload)
    );

    always #5 clk = ~clk;

    // store into the lowest free slot, or take the lowest matching slot
    function automatic reply_t lookup_or_store(input request_t r);
        reply_t res;
        logic   done;
        res  = '0;
        done = 1'b0;
        if (r.func == FUNC_PUT)
        begin
            for (int i = 0; i < ENTRIES && !done; i++)
            begin
                if (!pend_valid[i])
                begin
                    pend_valid[i]   = 1'b1;
                    pend_instant[i] = r.key;
                    pend_payload[i] = r.payload;
                    res.ok          = 1'b1;
                    done            = 1'b1;
                end
            end
        end
        else
        begin
            for (int i = 0; i < ENTRIES && !done; i++)
            begin
                if (pend_valid[i] && pend_instant[i] == r.key)
                begin
                    pend_valid[i] = 1'b0;
                    res.ok        = 1'b1;
                    res.instant   = pend_instant[i];
                    res.payload   = pend_payload[i];
                    done          = 1'b1;
                end
            end
        end
        return res;
    endfunction

    function automatic request_t mk_row(input logic f, input logic [INSTANT_BITS-1:0] k,
                                        input logic [PAYLOAD_BITS-1:0] p, input logic typed,
                                        input logic ok, input logic [INSTANT_BITS-1:0] inst,
                                        input logic [PAYLOAD_BITS-1:0] pay);
        request_t r;
        r.func        = f;
        r.key         = k;
        r.payload     = p;
        r.typed       = typed;
        r.exp_ok      = ok;
        r.exp_instant = inst;
        r.exp_payload = pay;
        return r;
    endfunction

    // random request, biased toward stored instants and toward filling or draining
    function automatic request_t draw_request();
        request_t                r;
        logic [63:0]             wide;
        logic [INSTANT_BITS-1:0] key_pool [4];
        int                      live [$];
        int                      put_pct;
        int                      pick;
        r           = '0;
        key_pool[0] = 16'h0000;
        key_pool[1] = 16'hFFFF;
        key_pool[2] = 16'h00A5;
        key_pool[3] = 16'h8001;
        for (int i = 0; i < ENTRIES; i++)
            if (pend_valid[i])
                live.push_back(i);
        put_pct = ((drawn_count / 40) % 2 == 0) ? 70 : 25;
        drawn_count++;

        // payload: mostly random, sometimes the extremes
        pick = $urandom_range(0, 9);
        wide = {$urandom, $urandom};
        if (pick == 0)
            r.payload = '1;
        else if (pick == 1)
            r.payload = '0;
        else
            r.payload = wide[PAYLOAD_BITS-1:0];

        pick = $urandom_range(0, 9);
        if ($urandom_range(0, 99) < put_pct)
        begin
            r.func = FUNC_PUT;
            if (pick < 4)
                r.key = key_pool[$urandom_range(0, 3)];
            else
                r.key = 16'($urandom_range(0, 65535));
        end
        else
        begin
            r.func = FUNC_GET;
            if (live.size() != 0 && $urandom_range(0, 99) < 70)
                r.key = pend_instant[live[$urandom_range(0, live.size() - 1)]];
            else if (pick < 3)
                r.key = key_pool[$urandom_range(0, 3)];
            else
                r.key = 16'($urandom_range(0, 65535));
        end
        return r;
    endfunction

    // offer one request and hold it until the block takes it
    task automatic offer_request(input request_t r);
        reply_t want;
        in_valid      <= 1'b1;
        func          <= r.func;
        key_instant   <= r.key;
        entry_payload <= r.payload;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        want = lookup_or_store(r);
        if (r.typed)
        begin
            want.ok      = r.exp_ok;
            want.instant = r.exp_instant;
            want.payload = r.exp_payload;
        end
        awaited_replies.push_back(want);
    endtask

    // sender: directed rows, then random bursts
    initial
    begin : stimulus
        request_t req;
        int       burst_left;
        int       gap;
        int       total;
        for (int i = 0; i < ENTRIES; i++)
        begin
            pend_valid[i]   = 1'b0;
            pend_instant[i] = '0;
            pend_payload[i] = '0;
        end

        // empty table, extremes, freed slot
        directed_rows.push_back(mk_row(FUNC_GET, 16'h0000, 48'h0, 1, 0, 16'h0, 48'h0));
        directed_rows.push_back(mk_row(FUNC_PUT, 16'hFFFF, 48'hFFFF_FFFF_FFFF, 1, 1, 16'h0,
                                       48'h0));
        directed_rows.push_back(mk_row(FUNC_PUT, 16'h0000, 48'h0, 1, 1, 16'h0, 48'h0));
        directed_rows.push_back(mk_row(FUNC_GET, 16'hFFFF, 48'h0, 1, 1, 16'hFFFF,
                                       48'hFFFF_FFFF_FFFF));
        directed_rows.push_back(mk_row(FUNC_GET, 16'h0000, 48'hFFFF_FFFF_FFFF, 1, 1, 16'h0,
                                       48'h0));
        directed_rows.push_back(mk_row(FUNC_GET, 16'h0000, 48'h0, 1, 0, 16'h0, 48'h0));
        // fill every slot, with a duplicate instant
        directed_rows.push_back(mk_row(FUNC_PUT, 16'h0100, 48'h0000_0000_0001, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(FUNC_PUT, 16'h0200, 48'h8000_0000_0000, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(FUNC_PUT, 16'h0100, 48'h5555_5555_5555, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(FUNC_PUT, 16'h8000, 48'hAAAA_AAAA_AAAA, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(FUNC_PUT, 16'h7FFF, 48'h1234_5678_9ABC, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(FUNC_PUT, 16'hAAAA, 48'hFFFF_0000_FFFF, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(FUNC_PUT, 16'h5555, 48'h0000_FFFF_0000, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(FUNC_PUT, 16'h0001, 48'hDEAD_BEEF_CAFE, 0, 0, 0, 0));
        // table full: nothing stored, so the get misses
        directed_rows.push_back(mk_row(FUNC_PUT, 16'h0300, 48'h0123_4567_89AB, 1, 0, 16'h0,
                                       48'h0));
        directed_rows.push_back(mk_row(FUNC_GET, 16'h0300, 48'h0, 1, 0, 16'h0, 48'h0));
        // duplicates come out lowest slot first
        directed_rows.push_back(mk_row(FUNC_GET, 16'h0100, 48'h0, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(FUNC_GET, 16'h0100, 48'h0, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(FUNC_GET, 16'h0100, 48'h0, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(FUNC_PUT, 16'h0100, 48'hFEDC_BA98_7654, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(FUNC_GET, 16'h0001, 48'h0, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(FUNC_GET, 16'h0100, 48'h0, 0, 0, 0, 0));
        directed_rows.push_back(mk_row(FUNC_GET, 16'h8000, 48'h0, 0, 0, 0, 0));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (3) @(posedge clk);

        total      = directed_rows.size() + RANDOM_ITEMS;
        burst_left = $urandom_range(1, 20);
        for (int n = 0; n < total; n++)
        begin
            if (n < directed_rows.size())
                req = directed_rows[n];
            else
                req = draw_request();
            offer_request(req);

            // idle between bursts
            burst_left--;
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 20);
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                if (gap > 0)
                begin
                    in_valid <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
        end
        in_valid <= 1'b0;

        // drain, then watch for stray replies
        while (awaited_replies.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    // receiver stall pattern, with long hold-offs to back up the block
    always @(posedge clk)
    begin
        rx_cycle <= rx_cycle + 1;
        if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else if (rx_cycle == 1500 || rx_cycle == 6000)
        begin
            hold_left <= 400;
            out_stall <= 1'b1;
        end
        else
        begin
            case ((rx_cycle / 512) % 4)
                0: out_stall <= 1'b0;
                1: out_stall <= ($urandom_range(0, 99) < 30);
                2: out_stall <= ($urandom_range(0, 99) < 75);
                default: out_stall <= ((rx_cycle % 7) < 3);
            endcase
        end
    end

    // reply checker
    always @(posedge clk)
    begin
        reply_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (awaited_replies.size() == 0)
            begin
                $display("%0t: reply with none pending: success %0d instant %h payload %h",
                         $time, success, out_instant, out_payload);
                error_count++;
            end
            else
            begin
                want = awaited_replies.pop_front();
                if (success !== want.ok)
                begin
                    $display("%0t: success expected %0d got %0d", $time, want.ok, success);
                    error_count++;
                end
                if (out_instant !== want.instant)
                begin
                    $display("%0t: out_instant expected %h got %h", $time, want.instant,
                             out_instant);
                    error_count++;
                end
                if (out_payload !== want.payload)
                begin
                    $display("%0t: out_payload expected %h got %h", $time, want.payload,
                             out_payload);
                    error_count++;
                end
            end
        end
    end

    // watchdog
    initial
    begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/core/ikpt_pkg.sv
rtl/core/ikpt_ctrl.sv
rtl/core/ikpt_datapath.sv
rtl/core/instant_keyed_pending_table_top.sv
test/instant_keyed_pending_table_top_tb.sv
